// ===== design/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// Types and constants shared by the flagella conformation tracker.
// ----------------------------------------------------------------------------
package fct_pkg;

    // Field widths fixed by the item formats.
    localparam int HOLD_W    = 24;
    localparam int STEP_W    = 16;
    localparam int MCNT_W    = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 24;
    localparam int MIDX_W    = 3;
    localparam int SHAPE_W   = 2;
    // Threshold sum of three 24-bit times never wraps in 26 bits.
    localparam int THR_W     = 26;
    // Motor counts up to 16 plus one fit in 5 bits.
    localparam int NCMP_W    = 5;

    // Flagellum shape codes.
    localparam logic [SHAPE_W-1:0] SHAPE_NORMAL = 2'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_SEMI   = 2'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_CURLY  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTORS_IN_USE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_NORMAL_RUN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_TO_SEMI  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CURLY_TO_NORMAL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SEMI_TIME   = 3'd5;

    // Configuration reset values.
    localparam logic [STEP_W-1:0]    RST_TIME_STEP       = 16'd10000;
    localparam logic [MCNT_W-1:0]    RST_MOTORS_IN_USE   = 4'd8;
    localparam logic [MCNT_W-1:0]    RST_MIN_NORMAL_RUN  = 4'd2;
    localparam logic [HOLD_W-1:0]    RST_NORMAL_TO_SEMI  = 24'd20000;
    localparam logic [HOLD_W-1:0]    RST_CURLY_TO_NORMAL = 24'd10000;
    localparam logic [HOLD_W-1:0]    RST_MIN_SEMI_TIME   = 24'd20000;

    typedef struct packed {
        logic              motor_ccw;
        logic [HOLD_W-1:0] semi_hold_time;
    } t_in_item;

    typedef struct packed {
        logic [MIDX_W-1:0]  motor_index;
        logic [SHAPE_W-1:0] flagellum_shape;
        logic               tick_done;
        logic               run;
        logic               previous_run;
    } t_out_item;

endpackage

// ===== design/flagella_conformation_tracker.sv =====
// ----------------------------------------------------------------------------
// flagella_conformation_tracker
// Per-motor flagellum shape tracking with a run or tumble decision per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid, o_in_stall, i_in_data) carries one motor's
//   direction and semi dwell time per transfer, motors in order 0 .. N-1,
//   where N is the motors_in_use register clamped to 1 .. MAX_MOTORS.
//   Output channel (o_out_valid, i_out_stall, o_out_data) returns one result
//   per input transfer: the motor index, its new shape and, on the last motor
//   of the tick, the run decision together with the previous tick's decision.
//   The result is registered and is valid in the cycle after its input transfer.
//   Throughput is one item per cycle unless a receiver stall holds a full
//   result register; the per-motor update is one saturating timer add, a
//   three-term threshold sum and three compares between input and result register.
//   When the receiver stalls, the result register holds its value and the
//   input side is stalled only while that register is full; a new item is
//   taken in the same cycle the held result leaves.
//   Configuration writes are always ready and must only be issued while no
//   items are in flight.
//   Reset (synchronous, active low) restores the register defaults, sets
//   every motor to clockwise with a curly flagellum, zero timers, and tumble.
// ----------------------------------------------------------------------------
module flagella_conformation_tracker #(
    parameter int MAX_MOTORS = 8,
    parameter int TIME_BITS  = 24
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  fct_pkg::t_in_item                   i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output fct_pkg::t_out_item                  o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fct_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [fct_pkg::CFG_DAT_W-1:0]       i_cfg_data
);
    import fct_pkg::*;

    localparam int CNT_W  = (MAX_MOTORS > 1) ? $clog2(MAX_MOTORS) : 1;
    localparam int TALLY_W = $clog2(MAX_MOTORS + 1);
    localparam int CMP_W  = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [NCMP_W-1:0]    MAX_N    = NCMP_W'(MAX_MOTORS);

    // Configuration registers.
    logic [STEP_W-1:0]    r_time_step;
    logic [MCNT_W-1:0]    r_motors_in_use;
    logic [MCNT_W-1:0]    r_min_normal_run;
    logic [HOLD_W-1:0]    r_normal_to_semi;
    logic [HOLD_W-1:0]    r_curly_to_normal;
    logic [HOLD_W-1:0]    r_min_semi_time;

    // Per-motor state.
    logic                 r_dir   [MAX_MOTORS];
    logic [TIME_BITS-1:0] r_timer [MAX_MOTORS];
    logic [HOLD_W-1:0]    r_hold  [MAX_MOTORS];
    logic [SHAPE_W-1:0]   r_shape [MAX_MOTORS];

    // Tick state.
    logic [CNT_W-1:0]     r_motor_cnt;
    logic [TALLY_W-1:0]   r_normal_cnt;
    logic [TALLY_W-1:0]   r_semi_cnt;
    logic                 r_swim;

    // Result register.
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 in_acc;
    logic                 cfg_acc;
    logic [NCMP_W-1:0]    eff_motors;
    logic                 cur_dir;
    logic                 to_cw;
    logic                 to_ccw;
    logic [TIME_BITS:0]   timer_sum;
    logic [TIME_BITS-1:0] n_timer;
    logic [HOLD_W-1:0]    n_hold;
    logic [THR_W-1:0]     curly_thr;
    logic [SHAPE_W-1:0]   n_shape;
    logic [TALLY_W-1:0]   n_normal_cnt;
    logic [TALLY_W-1:0]   n_semi_cnt;
    logic                 is_last;
    logic                 n_run;
    t_out_item            n_out;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        // Out-of-range motor counts are clamped to 1 .. MAX_MOTORS.
        if (r_motors_in_use == '0) begin
            eff_motors = NCMP_W'(1);
        end else if (NCMP_W'(r_motors_in_use) > MAX_N) begin
            eff_motors = MAX_N;
        end else begin
            eff_motors = NCMP_W'(r_motors_in_use);
        end

        cur_dir   = r_dir[r_motor_cnt];
        to_cw     = !i_in_data.motor_ccw && cur_dir;
        to_ccw    = i_in_data.motor_ccw && !cur_dir;

        // A direction switch restarts the timer at one step.
        if (to_cw || to_ccw) begin
            timer_sum = (TIME_BITS + 1)'(r_time_step);
        end else begin
            timer_sum = {1'b0, r_timer[r_motor_cnt]} + (TIME_BITS + 1)'(r_time_step);
        end
        n_timer = timer_sum[TIME_BITS] ? TIME_MAX : timer_sum[TIME_BITS-1:0];

        if (to_cw) begin
            n_hold = i_in_data.semi_hold_time;
        end else if (to_ccw) begin
            n_hold = '0;
        end else begin
            n_hold = r_hold[r_motor_cnt];
        end

        curly_thr = THR_W'(r_normal_to_semi) + THR_W'(r_min_semi_time) + THR_W'(n_hold);

        n_shape = r_shape[r_motor_cnt];
        if (!i_in_data.motor_ccw) begin
            if (CMP_W'(n_timer) > CMP_W'(curly_thr)) begin
                n_shape = SHAPE_CURLY;
            end else if (CMP_W'(n_timer) > CMP_W'(r_normal_to_semi)) begin
                n_shape = SHAPE_SEMI;
            end
        end else if (CMP_W'(n_timer) > CMP_W'(r_curly_to_normal)) begin
            n_shape = SHAPE_NORMAL;
        end

        n_normal_cnt = r_normal_cnt + TALLY_W'(n_shape == SHAPE_NORMAL);
        n_semi_cnt   = r_semi_cnt + TALLY_W'(n_shape == SHAPE_SEMI);

        is_last = (NCMP_W'(r_motor_cnt) + NCMP_W'(1)) >= eff_motors;
        n_run   = (NCMP_W'(n_normal_cnt) >= NCMP_W'(r_min_normal_run))
                  && (n_semi_cnt == '0);

        n_out.motor_index     = MIDX_W'(r_motor_cnt);
        n_out.flagellum_shape = n_shape;
        n_out.tick_done       = is_last;
        n_out.run             = is_last && n_run;
        n_out.previous_run    = is_last && r_swim;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step       <= RST_TIME_STEP;
            r_motors_in_use   <= RST_MOTORS_IN_USE;
            r_min_normal_run  <= RST_MIN_NORMAL_RUN;
            r_normal_to_semi  <= RST_NORMAL_TO_SEMI;
            r_curly_to_normal <= RST_CURLY_TO_NORMAL;
            r_min_semi_time   <= RST_MIN_SEMI_TIME;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                CFG_TIME_STEP:       r_time_step       <= i_cfg_data[STEP_W-1:0];
                CFG_MOTORS_IN_USE:   r_motors_in_use   <= i_cfg_data[MCNT_W-1:0];
                CFG_MIN_NORMAL_RUN:  r_min_normal_run  <= i_cfg_data[MCNT_W-1:0];
                CFG_NORMAL_TO_SEMI:  r_normal_to_semi  <= i_cfg_data[HOLD_W-1:0];
                CFG_CURLY_TO_NORMAL: r_curly_to_normal <= i_cfg_data[HOLD_W-1:0];
                CFG_MIN_SEMI_TIME:   r_min_semi_time   <= i_cfg_data[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_MOTORS; i++) begin
                r_dir[i]   <= 1'b0;
                r_timer[i] <= '0;
                r_hold[i]  <= '0;
                r_shape[i] <= SHAPE_CURLY;
            end
            r_motor_cnt  <= '0;
            r_normal_cnt <= '0;
            r_semi_cnt   <= '0;
            r_swim       <= 1'b0;
        end else if (in_acc) begin
            r_dir[r_motor_cnt]   <= i_in_data.motor_ccw;
            r_timer[r_motor_cnt] <= n_timer;
            r_hold[r_motor_cnt]  <= n_hold;
            r_shape[r_motor_cnt] <= n_shape;
            if (is_last) begin
                r_motor_cnt  <= '0;
                r_normal_cnt <= '0;
                r_semi_cnt   <= '0;
                r_swim       <= n_run;
            end else begin
                r_motor_cnt  <= r_motor_cnt + CNT_W'(1);
                r_normal_cnt <= n_normal_cnt;
                r_semi_cnt   <= n_semi_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_acc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out <= n_out;
        end
    end

    // The motor counter always addresses a motor that exists.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_motor_cnt) < MAX_MOTORS)
        else $error("motor counter out of range");

    // Ending a tick restarts the motor order and clears the tallies.
    a_tick_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_last |=> r_motor_cnt == '0 && r_normal_cnt == '0 && r_semi_cnt == '0)
        else $error("tick end did not restart counters");

    // The previous decision reported is the one held before this tick ended.
    a_prev_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && is_last |=> r_out.previous_run == $past(r_swim) && r_out.run == r_swim)
        else $error("run decision history mismatch");

    // Decisions are only reported on the last motor of a tick.
    a_run_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.tick_done |-> !o_out_data.run && !o_out_data.previous_run)
        else $error("decision reported outside tick end");

    // A stalled result is not overwritten.
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(r_out))
        else $error("stalled result changed");

endmodule

// ===== test/tb_flagella_conformation_tracker.sv =====
// ----------------------------------------------------------------------------
// tb_flagella_conformation_tracker
// Self-checking bench for the flagella conformation tracker. A predictor in
// the bench keeps its own copy of the per-motor timers, shapes and register
// settings and works out the result for every input transfer. Results are
// compared field by field, in order. Directed tests cover reset defaults,
// register extremes, a motor count change in the middle of a tick, back-pressure,
// a sender pause and timer saturation. Random tests use several register
// settings with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_flagella_conformation_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    import fct_pkg::*;

    localparam int MOTORS_MAX = 8;
    localparam int RESET_CYCLES = 12;
    localparam int PRINT_LIMIT = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
    localparam logic [HOLD_W-1:0] TIME_SAT = 24'hFFFFFF;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    flagella_conformation_tracker u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Register copy and motor state of the predictor.
    logic [STEP_W-1:0] cfg_step;
    logic [MCNT_W-1:0] cfg_motors;
    logic [MCNT_W-1:0] cfg_min_normal;
    logic [HOLD_W-1:0] cfg_normal_to_semi;
    logic [HOLD_W-1:0] cfg_curly_to_normal;
    logic [HOLD_W-1:0] cfg_min_semi;

    logic               dir_q   [MOTORS_MAX];
    logic [HOLD_W-1:0]  timer_q [MOTORS_MAX];
    logic [HOLD_W-1:0]  hold_q  [MOTORS_MAX];
    logic [SHAPE_W-1:0] shape_q [MOTORS_MAX];
    logic [MIDX_W-1:0]  motor_ptr;
    logic [MCNT_W-1:0]  normals;
    logic [MCNT_W-1:0]  semis;
    logic               swimming;

    t_out_item pending_results[$];

    int n_errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int settings_used = 0;

    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int rx_hold_left = 0;
    int rx_burst_left = 0;

    function automatic void clear_tracker();
        cfg_step            = RST_TIME_STEP;
        cfg_motors          = RST_MOTORS_IN_USE;
        cfg_min_normal      = RST_MIN_NORMAL_RUN;
        cfg_normal_to_semi  = RST_NORMAL_TO_SEMI;
        cfg_curly_to_normal = RST_CURLY_TO_NORMAL;
        cfg_min_semi        = RST_MIN_SEMI_TIME;
        for (int m = 0; m < MOTORS_MAX; m++) begin
            dir_q[m]   = 1'b0;
            timer_q[m] = '0;
            hold_q[m]  = '0;
            shape_q[m] = SHAPE_CURLY;
        end
        motor_ptr = '0;
        normals   = '0;
        semis     = '0;
        swimming  = 1'b0;
    endfunction

    function automatic void apply_setting(logic [CFG_IDX_W-1:0] idx,
                                          logic [CFG_DAT_W-1:0] data);
        case (idx)
            CFG_TIME_STEP:       cfg_step            = data[STEP_W-1:0];
            CFG_MOTORS_IN_USE:   cfg_motors          = data[MCNT_W-1:0];
            CFG_MIN_NORMAL_RUN:  cfg_min_normal      = data[MCNT_W-1:0];
            CFG_NORMAL_TO_SEMI:  cfg_normal_to_semi  = data[HOLD_W-1:0];
            CFG_CURLY_TO_NORMAL: cfg_curly_to_normal = data[HOLD_W-1:0];
            CFG_MIN_SEMI_TIME:   cfg_min_semi        = data[HOLD_W-1:0];
            default: ;
        endcase
    endfunction

    // Advances one motor and returns the result that its transfer produces.
    function automatic t_out_item track_motor(t_in_item it);
        logic [NCMP_W-1:0]  n_eff;
        logic [MIDX_W-1:0]  m;
        logic [HOLD_W:0]    sum;
        logic [HOLD_W-1:0]  tmr;
        logic [THR_W-1:0]   curl_thr;
        logic [SHAPE_W-1:0] shp;
        logic               last;
        t_out_item          r;

        if (cfg_motors == 0) n_eff = NCMP_W'(1);
        else if (cfg_motors > MOTORS_MAX) n_eff = NCMP_W'(MOTORS_MAX);
        else n_eff = NCMP_W'(cfg_motors);
        m = motor_ptr;

        sum = (HOLD_W+1)'(timer_q[m]) + (HOLD_W+1)'(cfg_step);
        tmr = sum[HOLD_W] ? TIME_SAT : sum[HOLD_W-1:0];
        if (!it.motor_ccw && dir_q[m]) begin
            tmr = HOLD_W'(cfg_step);
            hold_q[m] = it.semi_hold_time;
        end else if (it.motor_ccw && !dir_q[m]) begin
            tmr = HOLD_W'(cfg_step);
            hold_q[m] = '0;
        end
        timer_q[m] = tmr;

        // The curly threshold is a three-term sum kept wide enough not to wrap.
        curl_thr = THR_W'(cfg_normal_to_semi) + THR_W'(cfg_min_semi) + THR_W'(hold_q[m]);
        shp = shape_q[m];
        if (!it.motor_ccw) begin
            if (THR_W'(tmr) > curl_thr) shp = SHAPE_CURLY;
            else if (tmr > cfg_normal_to_semi) shp = SHAPE_SEMI;
        end else if (tmr > cfg_curly_to_normal) begin
            shp = SHAPE_NORMAL;
        end
        shape_q[m] = shp;
        dir_q[m]   = it.motor_ccw;

        if (shp == SHAPE_NORMAL) normals++;
        if (shp == SHAPE_SEMI) semis++;

        last = (NCMP_W'(m) + NCMP_W'(1) >= n_eff);
        r.motor_index     = m;
        r.flagellum_shape = shp;
        r.tick_done       = last;
        r.run             = 1'b0;
        r.previous_run    = 1'b0;
        if (last) begin
            r.previous_run = swimming;
            r.run = (normals >= cfg_min_normal) && (semis == 0);
            swimming  = r.run;
            normals   = '0;
            semis     = '0;
            motor_ptr = '0;
        end else begin
            motor_ptr = m + 1'b1;
        end
        return r;
    endfunction

    function automatic t_in_item make_item(logic ccw, logic [HOLD_W-1:0] hold);
        t_in_item it;
        it.motor_ccw      = ccw;
        it.semi_hold_time = hold;
        return it;
    endfunction

    // Direction of the next motor flips with the given percentage; dwell times
    // are mostly a few ticks long so that all three shapes show up.
    function automatic t_in_item random_item(int flip_pct);
        t_in_item it;
        it.motor_ccw = ($urandom_range(0, 99) < flip_pct) ? ~dir_q[motor_ptr]
                                                          : dir_q[motor_ptr];
        if ($urandom_range(0, 9) < 7)
            it.semi_hold_time = HOLD_W'(cfg_step * $urandom_range(0, 5));
        else
            it.semi_hold_time = HOLD_W'($urandom());
        return it;
    endfunction

    task automatic report_field(input string name, input logic [HOLD_W-1:0] want,
                                input logic [HOLD_W-1:0] got);
        n_errors++;
        if (n_errors <= PRINT_LIMIT)
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (pending_results.size() == 0) begin
            n_errors++;
            if (n_errors <= PRINT_LIMIT)
                $display("%0t ns: result with nothing pending, expected none, actual %p",
                         $time, got);
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (got.motor_index !== want.motor_index)
            report_field("motor_index", HOLD_W'(want.motor_index),
                         HOLD_W'(got.motor_index));
        if (got.flagellum_shape !== want.flagellum_shape)
            report_field("flagellum_shape", HOLD_W'(want.flagellum_shape),
                         HOLD_W'(got.flagellum_shape));
        if (got.tick_done !== want.tick_done)
            report_field("tick_done", HOLD_W'(want.tick_done), HOLD_W'(got.tick_done));
        if (got.run !== want.run)
            report_field("run", HOLD_W'(want.run), HOLD_W'(got.run));
        if (got.previous_run !== want.previous_run)
            report_field("previous_run", HOLD_W'(want.previous_run),
                         HOLD_W'(got.previous_run));
    endtask

    // Receiver: checks each transfer, then picks the stall for the next edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            check_result(o_out_data);
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_out_stall <= 1'b1;
        end else if (rx_burst_left > 0) begin
            rx_burst_left--;
            i_out_stall <= 1'b1;
        end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
            rx_burst_left = $urandom_range(1, 10) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_item(input t_in_item it);
        t_out_item want;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        want = track_motor(it);
        pending_results.insert(pending_results.size(), want);
        items_sent++;
    endtask

    task automatic tx_gap();
        if (tx_idle_en && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Leaves the write valid high so back-to-back writes need no toggle.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_setting(idx, data);
    endtask

    task automatic close_writes();
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [CFG_DAT_W-1:0] step, motors, min_run,
                              input logic [CFG_DAT_W-1:0] to_semi, to_normal, semi_min);
        wait_drain();
        write_reg(CFG_TIME_STEP, step);
        write_reg(CFG_MOTORS_IN_USE, motors);
        write_reg(CFG_MIN_NORMAL_RUN, min_run);
        write_reg(CFG_NORMAL_TO_SEMI, to_semi);
        write_reg(CFG_CURLY_TO_NORMAL, to_normal);
        write_reg(CFG_MIN_SEMI_TIME, semi_min);
        close_writes();
        settings_used++;
    endtask

    task automatic run_items(input int count, input int flip_pct);
        for (int i = 0; i < count; i++) begin
            tx_gap();
            send_item(random_item(flip_pct));
        end
    endtask

    // Two ticks at the reset settings; equal timer and threshold must not
    // change a shape, since the compares are strict.
    task automatic test_reset_defaults();
        logic [7:0] pat_a;
        logic [7:0] pat_b;
        pat_a = 8'b0101_0011;
        pat_b = 8'b1010_0110;
        for (int i = 0; i < MOTORS_MAX; i++) begin
            tx_gap();
            send_item(make_item(pat_a[i], i[0] ? TIME_SAT : '0));
        end
        for (int i = 0; i < MOTORS_MAX; i++) begin
            tx_gap();
            send_item(make_item(pat_b[i], i[1] ? TIME_SAT : '0));
        end
    endtask

    // Register data wider than the field, zero thresholds, motor counts out
    // of range both ways and the largest thresholds, whose sum must not wrap.
    task automatic test_register_extremes();
        wait_drain();
        write_reg(CFG_SPARE_LO, TIME_SAT);
        write_reg(CFG_SPARE_HI, '0);
        close_writes();
        set_config(TIME_SAT, TIME_SAT, '0, '0, '0, '0);
        run_items(6, 50);
        set_config(24'd1, '0, TIME_SAT, TIME_SAT, TIME_SAT, TIME_SAT);
        run_items(3, 50);
    endtask

    // Lowering the motor count mid-tick: past the new last motor the next
    // item ends the tick; short of it the tick goes on.
    task automatic test_motor_count_change();
        set_config(24'd10000, 24'd8, 24'd1, 24'd20000, 24'd10000, 24'd20000);
        run_items(5, 40);
        wait_drain();
        write_reg(CFG_MOTORS_IN_USE, 24'd3);
        close_writes();
        run_items(3, 40);
        wait_drain();
        write_reg(CFG_MOTORS_IN_USE, 24'd4);
        close_writes();
        run_items(4, 40);
    endtask

    // The receiver holds off long enough for the block to stall its input
    // while the sender keeps offering.
    task automatic test_back_pressure();
        wait_drain();
        tx_idle_en = 1'b0;
        rx_hold_left = 60;
        run_items(30, 30);
        tx_idle_en = 1'b1;
    endtask

    // The sender stops in the middle of a tick until every result is back.
    task automatic test_sender_pause();
        run_items(5, 30);
        wait_drain();
        run_items(7, 30);
    endtask

    task automatic test_random_settings();
        logic [CFG_DAT_W-1:0] step;
        logic [CFG_DAT_W-1:0] motors;
        logic [CFG_DAT_W-1:0] min_run;
        logic [CFG_DAT_W-1:0] thr [3];
        for (int p = 0; p < 4; p++) begin
            step = ($urandom_range(0, 9) < 7) ? CFG_DAT_W'($urandom_range(500, 20000))
                                              : CFG_DAT_W'($urandom_range(1, 65535));
            motors = ($urandom_range(0, 3) == 0) ? CFG_DAT_W'($urandom_range(0, 15))
                                                 : CFG_DAT_W'($urandom_range(1, 8));
            min_run = ($urandom_range(0, 4) == 0) ? CFG_DAT_W'($urandom_range(0, 15))
                                                  : CFG_DAT_W'($urandom_range(0, 4));
            for (int k = 0; k < 3; k++)
                thr[k] = ($urandom_range(0, 7) == 0) ? CFG_DAT_W'($urandom())
                                                     : CFG_DAT_W'(step * $urandom_range(0, 6));
            set_config(step, motors, min_run, thr[0], thr[1], thr[2]);
            run_items(72, 25);
        end
    endtask

    // One motor held clockwise at the longest tick: the timer saturates and
    // only the saturated value exceeds the semi threshold.
    task automatic test_timer_saturation();
        set_config(24'hFFFF, 24'd1, 24'd0, 24'hFFFFFE, 24'd0, 24'd1);
        for (int i = 0; i < 280; i++) begin
            tx_gap();
            send_item(make_item(1'b0, HOLD_W'($urandom())));
        end
    endtask

    task automatic test_steady_stream();
        set_config(24'd5000, 24'd8, 24'd3, 24'd15000, 24'd10000, 24'd5000);
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        run_items(100, 20);
    endtask

    initial begin
        clear_tracker();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_register_extremes();
        test_motor_count_change();
        test_back_pressure();
        test_sender_pause();
        test_random_settings();
        test_timer_saturation();
        test_steady_stream();

        wait_drain();
        repeat (5) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            n_errors++;
            $display("%0t ns: %0d results still pending at the end",
                     $time, pending_results.size());
        end
        $display("Covered %0d motor transfers and %0d checked results over %0d settings,",
                 items_sent, results_checked, settings_used);
        $display("with back-pressure, a sender pause, motor count changes and timer saturation.");
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results pending.", pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
design/fct_pkg.sv
design/flagella_conformation_tracker.sv
test/tb_flagella_conformation_tracker.sv
